// ===== rtl/core/tspr_pkg.sv =====
// ----------------------------------------------------------------------------
// tspr_pkg
// shared types and constants of the triggered sample player
// ----------------------------------------------------------------------------
package tspr_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int ADDR_W       = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CNT_W        = ($clog2(SAMPLE_DEPTH + 1) > 17) ?
                                  $clog2(SAMPLE_DEPTH + 1) : 17;

    localparam int IDX_W   = 16;
    localparam int SMP_W   = 16;
    localparam int LVL_W   = 13;
    localparam int RATE_W  = 24;
    localparam int SCNT_W  = 17;
    localparam int VOL_W   = 12;
    localparam int OUT_W   = 20;
    localparam int PHASE_W = 32;
    localparam int FRAC_W  = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LOW  = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [RATE_W-1:0] RATE_STEP_RST = 24'd65536;
    localparam logic [VOL_W-1:0]  VOLUME_RST    = 12'd1280;
    localparam logic signed [LVL_W-1:0] TRIG_HIGH_RST = 13'sd256;
    localparam logic signed [LVL_W-1:0] TRIG_LOW_RST  = 13'sd0;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_TRIG  = 8'b0000_0010,
        ST_RD0   = 8'b0000_0100,
        ST_RD1   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_SCALE = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load_write;
        logic capture;
        logic trig;
        logic rd0;
        logic rd1;
        logic mul;
        logic acc;
        logic scale;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/tspr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tspr_ctrl
// sequencer for load and tick transfers of the sample player
// ----------------------------------------------------------------------------
module tspr_ctrl
    import tspr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture    = accept;
                cmd.load_write = accept && (s_tuser == KIND_LOAD);
                if (accept && (s_tuser == KIND_TICK)) begin
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: begin
                cmd.trig   = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                cmd.rd0 = 1'b1;
                if (status.in_range) begin
                    state_next = ST_RD1;
                end else begin
                    state_next = ST_SCALE;
                end
            end
            ST_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tspr_datapath.sv =====
// ----------------------------------------------------------------------------
// tspr_datapath
// sample store, trigger, phase stepping, interpolation and gain
// ----------------------------------------------------------------------------
module tspr_datapath
    import tspr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  cmd_t                 cmd,
    output status_t              status
);

    logic [RATE_W-1:0]        rate_step_reg;
    logic [SCNT_W-1:0]        sample_count_reg;
    logic [VOL_W-1:0]         volume_reg;
    logic signed [LVL_W-1:0]  trig_high_reg;
    logic signed [LVL_W-1:0]  trig_low_reg;

    logic [SMP_W-1:0]         mem [SAMPLE_DEPTH];
    logic [SMP_W-1:0]         rd_data_reg;
    logic [ADDR_W-1:0]        rd_addr;

    logic [PHASE_W-1:0]       phase_reg;
    logic                     playing_reg;
    logic                     trig_state_reg;
    logic signed [SMP_W-1:0]  held_reg;
    logic signed [LVL_W-1:0]  level_reg;
    logic signed [SMP_W-1:0]  x0_reg;
    logic signed [32:0]       prod_reg;
    logic signed [28:0]       scaled_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic [IDX_W-1:0]         load_index;
    logic [SMP_W-1:0]         load_value;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         count_eff;
    logic [CNT_W-1:0]         idx_ext;
    logic [CNT_W-1:0]         idx1_ext;
    logic                     x1_valid;
    logic signed [SMP_W-1:0]  x1;
    logic signed [SMP_W:0]    diff;
    logic [PHASE_W:0]         phase_sum;
    logic signed [33:0]       acc;
    logic signed [17:0]       acc_q;
    logic signed [SMP_W-1:0]  held_next;
    logic                     rising;

    assign load_index = s_tdata[15:0];
    assign load_value = s_tdata[31:16];
    assign idx        = phase_reg[PHASE_W-1:FRAC_W];

    assign count_eff = (CNT_W'(sample_count_reg) < CNT_W'(SAMPLE_DEPTH)) ?
                       CNT_W'(sample_count_reg) : CNT_W'(SAMPLE_DEPTH);
    assign idx_ext   = CNT_W'(idx);
    assign idx1_ext  = idx_ext + CNT_W'(1);
    assign x1_valid  = idx1_ext < count_eff;

    assign status.in_range = playing_reg && (idx_ext < count_eff);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign rd_addr   = cmd.rd1 ? ADDR_W'(idx + IDX_W'(1)) : ADDR_W'(idx);
    assign x1        = x1_valid ? $signed(rd_data_reg) : '0;
    assign diff      = $signed({x1[SMP_W-1], x1}) - $signed({x0_reg[SMP_W-1], x0_reg});
    assign phase_sum = {1'b0, phase_reg} + (PHASE_W + 1)'(rate_step_reg);

    assign acc     = $signed({{2{x0_reg[SMP_W-1]}}, x0_reg, 16'h0000})
                   + $signed({prod_reg[32], prod_reg});
    assign acc_q   = acc[33:16];
    assign held_next = (acc[33] && (acc[15:0] != 16'h0000)) ?
                       SMP_W'(acc_q + 18'sd1) : SMP_W'(acc_q);

    assign rising = !trig_state_reg && (level_reg >= trig_high_reg);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_step_reg    <= RATE_STEP_RST;
            sample_count_reg <= '0;
            volume_reg       <= VOLUME_RST;
            trig_high_reg    <= TRIG_HIGH_RST;
            trig_low_reg     <= TRIG_LOW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RATE_STEP:    rate_step_reg    <= cfg_wdata[RATE_W-1:0];
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[SCNT_W-1:0];
                REG_VOLUME:       volume_reg       <= cfg_wdata[VOL_W-1:0];
                REG_TRIGGER_HIGH: trig_high_reg    <= $signed(cfg_wdata[LVL_W-1:0]);
                REG_TRIGGER_LOW:  trig_low_reg     <= $signed(cfg_wdata[LVL_W-1:0]);
                default: ;
            endcase
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (cmd.load_write && (CNT_W'(load_index) < CNT_W'(SAMPLE_DEPTH))) begin
            mem[ADDR_W'(load_index)] <= load_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // player state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            playing_reg    <= 1'b0;
            trig_state_reg <= 1'b0;
            held_reg       <= '0;
        end else begin
            if (cmd.trig) begin
                if (trig_state_reg) begin
                    if (level_reg <= trig_low_reg) begin
                        trig_state_reg <= 1'b0;
                    end
                end else if (rising) begin
                    trig_state_reg <= 1'b1;
                    phase_reg      <= '0;
                    playing_reg    <= 1'b1;
                end
            end
            if (cmd.rd0 && playing_reg && !status.in_range) begin
                held_reg    <= '0;
                playing_reg <= 1'b0;
                phase_reg   <= '0;
            end
            if (cmd.mul) begin
                phase_reg <= phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];
            end
            if (cmd.acc) begin
                held_reg <= held_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            level_reg <= $signed(s_tdata[44:32]);
        end
        if (cmd.rd1) begin
            x0_reg <= $signed(rd_data_reg);
        end
        if (cmd.mul) begin
            prod_reg <= 33'(diff * $signed({1'b0, phase_reg[FRAC_W-1:0]}));
        end
        if (cmd.scale) begin
            scaled_reg <= 29'(held_reg * $signed({1'b0, volume_reg}));
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {3'b000, playing_reg, scaled_reg[27:8]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/triggered_sample_player_resampling.sv =====
// ----------------------------------------------------------------------------
// triggered_sample_player_resampling
// one-shot sample player with linear interpolation and schmitt trigger
// ----------------------------------------------------------------------------
// Load transfers (s_tuser = 0) write one sample into the on-chip store. A
// tick transfer (s_tuser = 1) runs the trigger, two reads of the sample
// store, the interpolation multiply, the accumulate and the volume multiply
// in sequence and then registers its result. A tick while stopped, or one
// that reaches the end of the sample, skips the second read, the interpolation
// multiply and the accumulate. Either takes longer while the previous result
// has not been taken. s_tready is high only while no tick is in progress, so
// the next transfer is accepted in the cycle after the result is registered
// at the earliest. The result register lets the next load or tick be accepted
// while a result still waits on the master side. Each tick gives one result;
// loads give none. The store has no reset.
// ----------------------------------------------------------------------------
module triggered_sample_player_resampling
    import tspr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // load_index, load_value, trigger_level
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // out_level, play_active
);

    cmd_t    cmd;
    status_t status;

    tspr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tspr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tspr_scoreboard.sv =====
// ----------------------------------------------------------------------------
// tspr_scoreboard
// watches the load/tick stream, the register writes and the result stream of
// the sample player, runs its own copy of the trigger, the phase stepping and
// the linear interpolation, and compares every result transfer field by field
// ----------------------------------------------------------------------------
module tspr_scoreboard
    import tspr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // load_index, load_value, trigger_level
    input  logic                 s_tuser,   // kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // out_level, play_active
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [OUT_W-1:0] level;
        logic                    light;
    } tick_out_t;

    tick_out_t               due_q[$];
    logic signed [SMP_W-1:0] pcm [SAMPLE_DEPTH];

    logic [RATE_W-1:0]       rate;
    logic [SCNT_W-1:0]       scount;
    logic [VOL_W-1:0]        vol;
    logic signed [LVL_W-1:0] th;
    logic signed [LVL_W-1:0] tl;

    logic [PHASE_W-1:0]      ph;
    logic                    run;
    logic                    armed;
    logic signed [SMP_W-1:0] held;

    function automatic tick_out_t play_tick(input logic signed [LVL_W-1:0] lvl);
        logic        rising;
        int unsigned cnt;
        int unsigned pos;
        longint      x0;
        longint      x1;
        longint      frac;
        longint      acc;
        longint      prod;
        tick_out_t   r;
        rising = 1'b0;
        if (armed) begin
            if (lvl <= tl)
                armed = 1'b0;
        end else if (lvl >= th) begin
            armed  = 1'b1;
            rising = 1'b1;
        end
        if (rising) begin
            ph  = '0;
            run = 1'b1;
        end
        cnt = (scount < SCNT_W'(SAMPLE_DEPTH)) ? 32'(scount) : SAMPLE_DEPTH;
        if (run) begin
            pos = 32'(ph[PHASE_W-1:FRAC_W]);
            if (pos < cnt) begin
                frac = longint'(ph[FRAC_W-1:0]);
                x0   = pcm[pos];
                x1   = (pos + 1 < cnt) ? pcm[pos + 1] : 0;
                acc  = x0 * (65536 - frac) + x1 * frac;
                held = SMP_W'(acc / 65536);
                // phase sticks at the top instead of wrapping
                if (ph > 32'hFFFF_FFFF - rate)
                    ph = '1;
                else
                    ph = ph + rate;
            end else begin
                held = '0;
                run  = 1'b0;
                ph   = '0;
            end
        end
        prod    = longint'(held) * longint'(vol);
        prod    = prod >>> 8;
        r.level = prod[OUT_W-1:0];
        r.light = run;
        return r;
    endfunction

    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t want;
        if (!aresetn) begin
            rate   = RATE_STEP_RST;
            scount = '0;
            vol    = VOLUME_RST;
            th     = TRIG_HIGH_RST;
            tl     = TRIG_LOW_RST;
            ph     = '0;
            run    = 1'b0;
            armed  = 1'b0;
            held   = '0;
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.level = m_tdata[OUT_W-1:0];
                got.light = m_tdata[OUT_W];
                if (due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result transfer: level %0d light %0b",
                                 $realtime, got.level, got.light);
                end else begin
                    want = due_q.pop_front();
                    if (got.level !== want.level || got.light !== want.light) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t expected level/light %0d/%0b, got %0d/%0b",
                                     $realtime, want.level, want.light,
                                     got.level, got.light);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RATE_STEP:    rate   = cfg_wdata[RATE_W-1:0];
                    REG_SAMPLE_COUNT: scount = cfg_wdata[SCNT_W-1:0];
                    REG_VOLUME:       vol    = cfg_wdata[VOL_W-1:0];
                    REG_TRIGGER_HIGH: th     = cfg_wdata[LVL_W-1:0];
                    REG_TRIGGER_LOW:  tl     = cfg_wdata[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == KIND_LOAD)
                    pcm[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: SMP_W];
                else
                    due_q.push_back(play_tick(s_tdata[IDX_W+SMP_W +: LVL_W]));
            end
        end
        pending <= due_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the triggered sample player: fills the sample store, writes
// the five registers between phases, sends load and tick transfers with
// random gaps and back pressure, and reports the scoreboard verdict
// ----------------------------------------------------------------------------
module tb
    import tspr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREFIX      = 48;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int BIG_STEP    = 24'hFF0000;
    localparam int BIG_STRIDE  = 255;
    localparam int BIG_SPAN    = 258;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // load_index, load_value, trigger_level
    logic                 s_tuser   = 1'b0; // kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // out_level, play_active

    int mismatches;
    int pending;
    int tx_idle  = 29;
    int rx_idle  = 72;
    int quiet    = 0;
    int cur_th   = 256;
    int cur_tl   = 0;
    int hold_req = 0;
    bit gate     = 1'b0;

    triggered_sample_player_resampling DUT (.*);

    tspr_scoreboard u_scoreboard (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int pick(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int thresh();
        case ($urandom_range(6))
            0:       return -2560;
            1:       return 2560;
            2:       return pick(-4096, 4095);
            default: return pick(-2560, 2560);
        endcase
    endfunction

    task automatic offer(input logic kind, input logic [IDX_W-1:0] idx,
                         input logic [SMP_W-1:0] val, input logic [LVL_W-1:0] lvl);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, lvl, val, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] val);
        offer(KIND_LOAD, idx, val, LVL_W'($urandom));
    endtask

    task automatic tick(input int lvl);
        offer(KIND_TICK, IDX_W'($urandom), SMP_W'($urandom), lvl[LVL_W-1:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic wr_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DAT_W-1:0];
        @(posedge aclk);
    endtask

    task automatic set_regs(input int rate, input int count, input int vol,
                            input int th, input int tl);
        drain();
        repeat (SETTLE) @(posedge aclk);
        wr_reg(REG_RATE_STEP, rate);
        wr_reg(REG_SAMPLE_COUNT, count);
        wr_reg(REG_VOLUME, vol);
        wr_reg(REG_TRIGGER_HIGH, th);
        wr_reg(REG_TRIGGER_LOW, tl);
        cfg_wr_en <= 1'b0;
        cur_th = th;
        cur_tl = tl;
    endtask

    task automatic rand_regs();
        int rate;
        int count;
        int vol;
        case ($urandom_range(7))
            0:       rate = 1;
            1:       rate = 24'hFFFFFF;
            2:       rate = 0;
            3:       rate = $urandom_range(24'hFFFFFF);
            default: rate = pick(24'h2000, 24'h30000);
        endcase
        case ($urandom_range(4))
            0:       count = 0;
            1:       count = 1;
            2:       count = PREFIX;
            default: count = pick(2, PREFIX);
        endcase
        case ($urandom_range(5))
            0:       vol = 0;
            1:       vol = 2560;
            2:       vol = $urandom_range(4095);
            default: vol = pick(0, 2560);
        endcase
        set_regs(rate, count, vol, thresh(), thresh());
    endtask

    // trigger level mostly follows a gate that sits above or below the thresholds
    task automatic rand_run(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(149) == 0)
                drain();
            if ($urandom_range(9) < 3) begin
                load(IDX_W'($urandom_range(9) < 7 ? $urandom_range(PREFIX - 1) : $urandom),
                     SMP_W'($urandom));
            end else begin
                if ($urandom_range(99) < 8)
                    gate = !gate;
                if ($urandom_range(9) == 0)
                    tick(pick(-4096, 4095));
                else if (gate)
                    tick(pick(cur_th, cur_th > 2560 ? cur_th : 2560));
                else
                    tick(pick(cur_tl < -2560 ? cur_tl : -2560, cur_tl));
            end
        end
    endtask

    // whole-store playback: the phase only lands on multiples of the stride
    task automatic big_run(input int count);
        set_regs(int'(RATE_STEP_RST), 0, int'(VOLUME_RST), 256, 0);
        tick(-2560);
        set_regs(BIG_STEP, count, pick(0, 2560), 256, 0);
        for (int k = 0; k < BIG_SPAN + 8; k++)
            tick(2560);
        tick(-2560);
        for (int k = 0; k < 6; k++)
            tick(2560);
    endtask

    initial begin
        int hold_done;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, empty store: playback stops on the tick that starts it
        tick(255);
        tick(256);
        tick(-2560);
        for (int k = 0; k < PREFIX; k++)
            load(IDX_W'(k),
                 SMP_W'(k == 0 ? 16'h8000 : k == 1 ? 16'h7FFF : k == 2 ? 16'hFFFF : $urandom));

        set_regs(int'(RATE_STEP_RST), PREFIX, 2560, 2560, -2560);
        tick(2559);
        tick(2560);
        tick(0);
        tick(-2559);
        tick(-2560);
        tick(2560);
        tick(2560);
        // falling threshold above the rising one
        set_regs(1, 2, 0, -100, 100);
        tick(-100);
        tick(50);
        tick(100);
        tick(-100);
        // frozen phase
        set_regs(0, 2, int'(VOLUME_RST), 256, 0);
        tick(300);
        tick(0);
        tick(256);
        tick(256);
        set_regs(24'hFFFFFF, 1, 2560, 256, 0);
        tick(-4096);
        tick(4095);
        tick(4095);

        for (int p = 0; p < 5; p++) begin
            rand_regs();
            if (p == 1)
                hold_req = hold_req + 1;
            rand_run(30);
        end

        tx_idle = 72;
        rx_idle = 29;
        for (int k = 0; k < BIG_SPAN; k++) begin
            load(IDX_W'(k * BIG_STRIDE), SMP_W'($urandom));
            if (k * BIG_STRIDE + 1 < SAMPLE_DEPTH)
                load(IDX_W'(k * BIG_STRIDE + 1), SMP_W'($urandom));
        end
        for (int p = 0; p < 5; p++) begin
            rand_regs();
            rand_run(30);
        end
        big_run(SAMPLE_DEPTH);

        tx_idle = 0;
        rx_idle = 0;
        for (int p = 0; p < 5; p++) begin
            rand_regs();
            if (p == 0)
                hold_req = hold_req + 1;
            rand_run(30);
        end
        big_run(2 ** SCNT_W - 1);

        drain();
        repeat (2 * SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
